// File: rtl/core/akf_pkg.sv
// Package for the angle Kalman filter: widths, register indexes, reset values,
// multiplier shift codes and the saturation helper.
// No dependencies.
package akf_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned CovW    = 32;
  localparam int unsigned NoiseW  = 24;
  localparam int unsigned TimeW   = 24;
  localparam int unsigned MulAW   = 34;
  localparam int unsigned MulBW   = 32;
  localparam int unsigned MulOutW = 36;
  localparam int unsigned SumW    = 38;

  localparam logic [1:0] CFG_QA = 2'd0;
  localparam logic [1:0] CFG_QB = 2'd1;
  localparam logic [1:0] CFG_R  = 2'd2;

  localparam logic [NoiseW-1:0] QA_RST = 24'd134218;
  localparam logic [NoiseW-1:0] QB_RST = 24'd50332;
  localparam logic [NoiseW-1:0] R_RST  = 24'd167772;

  localparam logic signed [CovW-1:0] COV_ONE = 32'sh4000_0000;

  typedef enum logic [1:0] {
    SH_18 = 2'd0,
    SH_24 = 2'd1,
    SH_30 = 2'd2
  } shift_e;

  function automatic logic signed [31:0] sat32(input logic signed [SumW-1:0] v);
    logic hi_same;
    hi_same = (v[SumW-1:31] == '0) || (v[SumW-1:31] == '1);
    if (hi_same) return v[31:0];
    else if (v[SumW-1]) return 32'sh8000_0000;
    else return 32'sh7fff_ffff;
  endfunction

endpackage

// File: rtl/core/akf_mul.sv
// Shared signed multiplier with floor shift and a registered result.
// Depends on akf_pkg.
module akf_mul (
  input  logic                                clk_i,
  input  logic signed [akf_pkg::MulAW-1:0]    a_i,
  input  logic signed [akf_pkg::MulBW-1:0]    b_i,
  input  akf_pkg::shift_e                     shift_i,
  output logic signed [akf_pkg::MulOutW-1:0]  prod_o
);

  logic signed [akf_pkg::MulAW+akf_pkg::MulBW-1:0] full;
  logic signed [akf_pkg::MulOutW-1:0]              prod_d, prod_q;

  assign full = a_i * b_i;

  // arithmetic shift gives floor rounding
  always_comb begin
    case (shift_i)
      akf_pkg::SH_18: prod_d = akf_pkg::MulOutW'(full >>> 18);
      akf_pkg::SH_24: prod_d = akf_pkg::MulOutW'(full >>> 24);
      akf_pkg::SH_30: prod_d = akf_pkg::MulOutW'(full >>> 30);
      default:        prod_d = akf_pkg::MulOutW'(full >>> 30);
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

// File: rtl/core/akf_div.sv
// Radix-2 restoring divider for the gains: sat32(trunc(num * 2^30 / den)).
// Depends on akf_pkg. den must be positive.
module akf_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [31:0]      num_i,
  input  logic [31:0]             den_i,
  output logic                    done_o,
  output logic signed [31:0]      quo_o
);

  logic [31:0] mag;
  logic        busy_d, busy_q, done_d, done_q;
  logic [4:0]  cnt_d, cnt_q;
  logic [31:0] rem_d, rem_q, sh_d, sh_q, quo_d, quo_q, den_d, den_q;
  logic        neg_d, neg_q, ovf_d, ovf_q;
  logic [32:0] trial;
  logic        fits;

  assign mag   = num_i[31] ? (~num_i + 32'd1) : num_i;
  assign trial = {rem_q, sh_q[31]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    ovf_d  = ovf_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'd31;
      neg_d  = num_i[31];
      den_d  = den_i;
      // quotient of 2^32 or more saturates either way
      ovf_d  = {2'b00, mag[31:2]} >= den_i;
      rem_d  = {2'b00, mag[31:2]};
      sh_d   = {mag[1:0], 30'd0};
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? 32'(trial - {1'b0, den_q}) : trial[31:0];
      sh_d  = {sh_q[30:0], 1'b0};
      quo_d = {quo_q[30:0], fits};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
    ovf_q <= ovf_d;
  end

  always_comb begin
    if (neg_q) begin
      quo_o = (ovf_q || quo_q > 32'h8000_0000) ? 32'sh8000_0000 : $signed(~quo_q + 32'd1);
    end else begin
      quo_o = (ovf_q || quo_q[31]) ? 32'sh7fff_ffff : $signed(quo_q);
    end
  end

  assign done_o = done_q;

endmodule

// File: rtl/core/angle_kalman_filter.sv
// Two-state angle/gyro-bias Kalman filter, top level with sequencer.
// Depends on akf_pkg, akf_mul, akf_div.
//
// One update transaction runs from acceptance to a valid result through
// sixteen sequencer steps, ten of which feed the shared multiplier, plus two
// passes of the one-bit-per-cycle gain divider. When the innovation
// variance is not positive the divider and correction are skipped;
// a reinitialize transaction goes from idle straight to the output step. The input is ready only while the
// sequencer is idle; the result sits in an output register, so a new item can
// be accepted while the last result waits.
// Configuration writes are always accepted; index 3 is ignored.
module angle_kalman_filter (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [87:0]  s_axis_tdata_i,  // accel_angle[31:0], gyro_dps[63:32], time_step[87:64]
  input  logic         s_axis_tuser_i,  // action
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [31:0]  m_axis_tdata_o,  // angle_estimate[31:0]
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_addr_i,
  input  logic [23:0]  cfg_data_i
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_RATE  = 5'd1;
  localparam logic [4:0] ST_MT    = 5'd2;
  localparam logic [4:0] ST_MQB   = 5'd3;
  localparam logic [4:0] ST_INNER = 5'd4;
  localparam logic [4:0] ST_MINN  = 5'd5;
  localparam logic [4:0] ST_P00   = 5'd6;
  localparam logic [4:0] ST_SCOMP = 5'd7;
  localparam logic [4:0] ST_CHK   = 5'd8;
  localparam logic [4:0] ST_DIV0  = 5'd9;
  localparam logic [4:0] ST_DIV1  = 5'd10;
  localparam logic [4:0] ST_YK0   = 5'd11;
  localparam logic [4:0] ST_YK1   = 5'd12;
  localparam logic [4:0] ST_P00K0 = 5'd13;
  localparam logic [4:0] ST_P00K1 = 5'd14;
  localparam logic [4:0] ST_P01K0 = 5'd15;
  localparam logic [4:0] ST_P01K1 = 5'd16;
  localparam logic [4:0] ST_P11   = 5'd17;
  localparam logic [4:0] ST_OUT   = 5'd18;

  localparam int unsigned SW = akf_pkg::SumW;

  logic [4:0] state_d, state_q;

  logic [23:0] qa_q, qb_q, r_q;

  logic signed [31:0] ang_d, ang_q, bias_d, bias_q;
  logic signed [31:0] p00_d, p00_q, p01_d, p01_q, p10_d, p10_q, p11_d, p11_q;
  logic signed [31:0] acc_d, acc_q, gyro_d, gyro_q;
  logic [23:0]        dt_d, dt_q;
  logic signed [31:0] t_d, t_q, k0_d, k0_q, k1_d, k1_q;
  logic signed [33:0] inner_d, inner_q;
  logic signed [32:0] s_d, s_q, y_d, y_q;

  logic                                  out_valid_d, out_valid_q;
  logic [31:0]                           out_data_d, out_data_q;

  logic signed [akf_pkg::MulAW-1:0]      mul_a;
  logic signed [akf_pkg::MulBW-1:0]      mul_b;
  akf_pkg::shift_e                       mul_sh;
  logic signed [akf_pkg::MulOutW-1:0]    prod;

  logic                                  div_start, div_done;
  logic signed [31:0]                    div_num, div_quo;

  logic signed [akf_pkg::MulBW-1:0]      dt_op;
  logic                                  s_pos;

  assign dt_op = $signed({8'd0, dt_q});
  assign s_pos = !s_q[32] && (s_q != '0);

  akf_mul u_mul (
    .clk_i   (clk_i),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .shift_i (mul_sh),
    .prod_o  (prod)
  );

  akf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (s_q[31:0]),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // multiplier operand select
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_sh = akf_pkg::SH_30;
    case (state_q)
      ST_RATE: begin
        mul_a  = 34'(gyro_q) - 34'(bias_q);
        mul_b  = dt_op;
        mul_sh = akf_pkg::SH_24;
      end
      ST_MT: begin
        mul_a  = 34'(p11_q);
        mul_b  = dt_op;
        mul_sh = akf_pkg::SH_24;
      end
      ST_MQB: begin
        mul_a  = $signed(34'(qb_q));
        mul_b  = dt_op;
        mul_sh = akf_pkg::SH_18;
      end
      ST_MINN: begin
        mul_a  = inner_q;
        mul_b  = dt_op;
        mul_sh = akf_pkg::SH_24;
      end
      ST_YK0: begin
        mul_a = 34'(y_q);
        mul_b = k0_q;
      end
      ST_YK1: begin
        mul_a = 34'(y_q);
        mul_b = k1_q;
      end
      ST_P00K0: begin
        mul_a = 34'(p00_q);
        mul_b = k0_q;
      end
      ST_P00K1: begin
        mul_a = 34'(p00_q);
        mul_b = k1_q;
      end
      ST_P01K0: begin
        mul_a = 34'(p01_q);
        mul_b = k0_q;
      end
      ST_P01K1: begin
        mul_a = 34'(p01_q);
        mul_b = k1_q;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    ang_d       = ang_q;
    bias_d      = bias_q;
    p00_d       = p00_q;
    p01_d       = p01_q;
    p10_d       = p10_q;
    p11_d       = p11_q;
    acc_d       = acc_q;
    gyro_d      = gyro_q;
    dt_d        = dt_q;
    t_d         = t_q;
    inner_d     = inner_q;
    s_d         = s_q;
    y_d         = y_q;
    k0_d        = k0_q;
    k1_d        = k1_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    div_start   = 1'b0;
    div_num     = p00_q;

    if (out_valid_q && m_axis_tready_i) out_valid_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          if (s_axis_tuser_i) begin
            ang_d   = '0;
            bias_d  = '0;
            p00_d   = akf_pkg::COV_ONE;
            p01_d   = '0;
            p10_d   = '0;
            p11_d   = akf_pkg::COV_ONE;
            state_d = ST_OUT;
          end else begin
            acc_d   = $signed(s_axis_tdata_i[31:0]);
            gyro_d  = $signed(s_axis_tdata_i[63:32]);
            dt_d    = s_axis_tdata_i[87:64];
            state_d = ST_RATE;
          end
        end
      end
      ST_RATE: state_d = ST_MT;
      ST_MT: begin
        ang_d   = akf_pkg::sat32(SW'(ang_q) + SW'(prod));
        state_d = ST_MQB;
      end
      ST_MQB: begin
        t_d     = prod[31:0];
        state_d = ST_INNER;
      end
      ST_INNER: begin
        p11_d   = akf_pkg::sat32(SW'(p11_q) + SW'(prod));
        inner_d = 34'(t_q) - 34'(p01_q) - 34'(p10_q) + $signed(34'({qa_q, 6'd0}));
        p01_d   = akf_pkg::sat32(SW'(p01_q) - SW'(t_q));
        p10_d   = akf_pkg::sat32(SW'(p10_q) - SW'(t_q));
        state_d = ST_MINN;
      end
      ST_MINN: state_d = ST_P00;
      ST_P00: begin
        p00_d   = akf_pkg::sat32(SW'(p00_q) + SW'(prod));
        state_d = ST_SCOMP;
      end
      ST_SCOMP: begin
        s_d     = 33'(p00_q) + $signed(33'({r_q, 6'd0}));
        y_d     = 33'(acc_q) - 33'(ang_q);
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (s_pos) begin
          div_start = 1'b1;
          div_num   = p00_q;
          state_d   = ST_DIV0;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_DIV0: begin
        if (div_done) begin
          k0_d      = div_quo;
          div_start = 1'b1;
          div_num   = p10_q;
          state_d   = ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (div_done) begin
          k1_d    = div_quo;
          state_d = ST_YK0;
        end
      end
      ST_YK0: state_d = ST_YK1;
      ST_YK1: begin
        ang_d   = akf_pkg::sat32(SW'(ang_q) + SW'(prod));
        state_d = ST_P00K0;
      end
      ST_P00K0: begin
        bias_d  = akf_pkg::sat32(SW'(bias_q) + SW'(prod));
        state_d = ST_P00K1;
      end
      // p00 and p01 are each overwritten in the same cycle that their old
      // value goes into the multiplier for the last time
      ST_P00K1: begin
        p00_d   = akf_pkg::sat32(SW'(p00_q) - SW'(prod));
        state_d = ST_P01K0;
      end
      ST_P01K0: begin
        p10_d   = akf_pkg::sat32(SW'(p10_q) - SW'(prod));
        state_d = ST_P01K1;
      end
      ST_P01K1: begin
        p01_d   = akf_pkg::sat32(SW'(p01_q) - SW'(prod));
        state_d = ST_P11;
      end
      ST_P11: begin
        p11_d   = akf_pkg::sat32(SW'(p11_q) - SW'(prod));
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = ang_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      qa_q        <= akf_pkg::QA_RST;
      qb_q        <= akf_pkg::QB_RST;
      r_q         <= akf_pkg::R_RST;
      ang_q       <= '0;
      bias_q      <= '0;
      p00_q       <= akf_pkg::COV_ONE;
      p01_q       <= '0;
      p10_q       <= '0;
      p11_q       <= akf_pkg::COV_ONE;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      ang_q       <= ang_d;
      bias_q      <= bias_d;
      p00_q       <= p00_d;
      p01_q       <= p01_d;
      p10_q       <= p10_d;
      p11_q       <= p11_d;
      if (cfg_valid_i) begin
        case (cfg_addr_i)
          akf_pkg::CFG_QA: qa_q <= cfg_data_i;
          akf_pkg::CFG_QB: qb_q <= cfg_data_i;
          akf_pkg::CFG_R:  r_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    gyro_q     <= gyro_d;
    dt_q       <= dt_d;
    t_q        <= t_d;
    inner_q    <= inner_d;
    s_q        <= s_d;
    y_q        <= y_d;
    k0_q       <= k0_d;
    k1_q       <= k1_d;
    out_data_q <= out_data_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign cfg_ready_o     = 1'b1;

endmodule
